[rtl/paf_pkg.sv]
// Shared types, constants and helpers for the Pareto archive filter.
`default_nettype none
package paf_pkg;

    localparam int ARCH_CAP = 64;
    localparam int MAX_MET  = 16;
    localparam int ENTRY_W  = $clog2(ARCH_CAP);
    localparam int MET_W    = $clog2(MAX_MET);
    localparam int CNT_W    = ENTRY_W + 1;
    localparam int MPOS_W   = MET_W + 1;
    localparam int MADDR_W  = ENTRY_W + MET_W;
    localparam int SEEN_W   = 20;
    localparam int DATA_W   = 32;
    localparam int MC_W     = 5;
    localparam int PADDR_W  = 3;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    localparam logic [2:0] V_REPLACED = 3'd0;
    localparam logic [2:0] V_APPENDED = 3'd1;
    localparam logic [2:0] V_DISCARD  = 3'd2;
    localparam logic [2:0] V_DROPPED  = 3'd3;
    localparam logic [2:0] V_READ_OK  = 3'd4;
    localparam logic [2:0] V_READ_BAD = 3'd5;

    localparam logic REG_METRIC_COUNT = 1'b0;
    localparam logic REG_CAND_LIMIT   = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] metric_value;
        logic               last_value;
        logic [31:0]        candidate_tag;
        logic [5:0]         entry_index;
        logic [3:0]         metric_sel;
    } t_in;

    typedef struct packed {
        logic [2:0]         verdict;
        logic [6:0]         entry_count;
        logic [5:0]         removed_count;
        logic               finished;
        logic signed [31:0] read_value;
        logic [31:0]        read_tag;
    } t_out;

    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [MET_W-1:0] wr_idx;
        logic [MET_W-1:0] rd_idx;
    } t_cand_ctl;

    // Clamp the configured metric count into 1 .. MAX_MET.
    function automatic logic [MPOS_W-1:0] used_metrics(input logic [MC_W-1:0] mc);
        logic [MPOS_W-1:0] res;
        if (mc == '0) begin
            res = MPOS_W'(1);
        end else if (32'(mc) > MAX_MET) begin
            res = MPOS_W'(MAX_MET);
        end else begin
            res = MPOS_W'(mc);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/paf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module paf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/paf_cand.sv]
// Candidate buffer: metric values of the candidate being loaded, unloaded slots read as zero.
`default_nettype none
module paf_cand (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire paf_pkg::t_cand_ctl      i_ctl,
    input  wire logic [paf_pkg::DATA_W-1:0] i_wdata,
    output logic      [paf_pkg::DATA_W-1:0] o_rdata
);
    logic [paf_pkg::DATA_W-1:0]  r_data [paf_pkg::MAX_MET];
    logic [paf_pkg::MAX_MET-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.wr) begin
            r_vld[i_ctl.wr_idx] <= 1'b1;
        end
        if (i_ctl.wr) begin
            r_data[i_ctl.wr_idx] <= i_wdata;
        end
    end

    // drop stale values: a slot not loaded since the last clear reads as zero
    assign o_rdata = r_vld[i_ctl.rd_idx] ? r_data[i_ctl.rd_idx] : '0;
endmodule
`default_nettype wire

[rtl/pareto_archive_filter_top.sv]
// Top level of the Pareto archive filter: sequencer, archive memories and config port.
// A load item without the last flag is taken in S_IDLE and leaves the sequencer there; a read
// result is registered through S_READ and S_DONE into the output register (S_DONE only when out
// of range), and S_DONE waits while the output register is full. One item is in work at a time.
// A closing load walks the archive over the clamped metric count per entry, writes all MAX_MET
// words of a replaced or appended row, and when compacting copies each moved entry in full.
// Reset (synchronous, active low) clears counters, flags and sequencer; archive RAMs stay as is.
`default_nettype none
module pareto_archive_filter_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire paf_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output paf_pkg::t_out                    o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [paf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CMP   = 8'b0000_0010,
        S_END   = 8'b0000_0100,
        S_WRITE = 8'b0000_1000,
        S_COPY  = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [paf_pkg::MC_W-1:0]   r_metric_count;
    logic [paf_pkg::SEEN_W-1:0] r_cand_limit;

    // archive bookkeeping
    logic [paf_pkg::CNT_W-1:0]    r_valid;
    logic [paf_pkg::MPOS_W-1:0]   r_load_pos;
    logic [paf_pkg::SEEN_W-1:0]   r_seen;
    logic                         r_finished;
    logic [paf_pkg::ARCH_CAP-1:0] r_keep;

    // walk and copy sequencing
    logic [paf_pkg::CNT_W-1:0]   r_j;
    logic [paf_pkg::CNT_W-1:0]   r_dst;
    logic [paf_pkg::MPOS_W-1:0]  r_i;
    logic                        r_pv;
    logic [paf_pkg::MET_W-1:0]   r_pi;
    logic                        r_cb;
    logic                        r_eb;
    logic                        r_placed;
    logic                        r_append;
    logic [paf_pkg::ENTRY_W-1:0] r_wrow;

    // result staging
    logic [2:0]                 r_verdict;
    logic [5:0]                 r_removed;
    logic [paf_pkg::DATA_W-1:0] r_rval;
    logic [paf_pkg::DATA_W-1:0] r_rtag;
    logic [paf_pkg::DATA_W-1:0] r_tag;
    logic                       r_out_valid;
    paf_pkg::t_out              r_out;

    logic [paf_pkg::SEEN_W-1:0] n_seen;
    logic [paf_pkg::MPOS_W-1:0] used_n;
    logic                       in_xfer;
    logic                       in_range;
    logic                       cmp_gt;
    logic                       cmp_lt;
    logic                       cb_f;
    logic                       eb_f;
    logic                       out_free;

    paf_pkg::t_cand_ctl         cand_ctl;
    logic [paf_pkg::DATA_W-1:0] cand_rdata;

    logic                        met_we;
    logic [paf_pkg::MADDR_W-1:0] met_waddr;
    logic [paf_pkg::MADDR_W-1:0] met_raddr;
    logic [paf_pkg::DATA_W-1:0]  met_wdata;
    logic [paf_pkg::DATA_W-1:0]  met_rdata;
    logic                        tag_we;
    logic [paf_pkg::ENTRY_W-1:0] tag_waddr;
    logic [paf_pkg::ENTRY_W-1:0] tag_raddr;
    logic [paf_pkg::DATA_W-1:0]  tag_wdata;
    logic [paf_pkg::DATA_W-1:0]  tag_rdata;

    assign used_n   = paf_pkg::used_metrics(r_metric_count);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer  = i_in_valid && o_in_ready;
    assign in_range = ({1'b0, i_in_data.entry_index} < r_valid)
                   && ({1'b0, i_in_data.metric_sel} < used_n);
    assign out_free = !r_out_valid || i_out_ready;

    // candidate against stored metric, both signed
    assign cmp_gt = $signed(cand_rdata) > $signed(met_rdata);
    assign cmp_lt = $signed(cand_rdata) < $signed(met_rdata);
    assign cb_f   = r_cb || (r_pv && cmp_gt);
    assign eb_f   = r_eb || (r_pv && cmp_lt);

    assign n_seen = (r_seen == paf_pkg::SEEN_MAX) ? r_seen : r_seen + 1'b1;

    // candidate buffer port: load in idle, read along the walk or the row write
    always_comb begin
        cand_ctl.wr     = in_xfer && (i_in_data.command == paf_pkg::CMD_LOAD)
                       && (r_load_pos < paf_pkg::MPOS_W'(paf_pkg::MAX_MET));
        cand_ctl.wr_idx = r_load_pos[paf_pkg::MET_W-1:0];
        cand_ctl.clr    = (r_state == S_FIN);
        cand_ctl.rd_idx = (r_state == S_WRITE) ? r_i[paf_pkg::MET_W-1:0] : r_pi;
    end

    // archive memory ports
    always_comb begin
        met_we    = (r_state == S_WRITE) || ((r_state == S_COPY) && r_pv);
        met_waddr = (r_state == S_WRITE) ? {r_wrow, r_i[paf_pkg::MET_W-1:0]}
                                         : {r_dst[paf_pkg::ENTRY_W-1:0], r_pi};
        met_wdata = (r_state == S_WRITE) ? cand_rdata : met_rdata;
        met_raddr = (r_state == S_IDLE) ? {i_in_data.entry_index, i_in_data.metric_sel}
                                        : {r_j[paf_pkg::ENTRY_W-1:0],
                                           r_i[paf_pkg::MET_W-1:0]};
        tag_we    = ((r_state == S_WRITE) && (r_i == '0))
                 || ((r_state == S_COPY) && r_pv && (r_pi == '0));
        tag_waddr = (r_state == S_WRITE) ? r_wrow : r_dst[paf_pkg::ENTRY_W-1:0];
        tag_wdata = (r_state == S_WRITE) ? r_tag : tag_rdata;
        tag_raddr = (r_state == S_IDLE) ? i_in_data.entry_index
                                        : r_j[paf_pkg::ENTRY_W-1:0];
    end

    paf_cand u_cand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cand_ctl),
        .i_wdata (i_in_data.metric_value),
        .o_rdata (cand_rdata)
    );

    paf_ram #(
        .WIDTH (paf_pkg::DATA_W),
        .DEPTH (paf_pkg::ARCH_CAP * paf_pkg::MAX_MET)
    ) u_met_ram (
        .i_clk   (i_clk),
        .i_we    (met_we),
        .i_waddr (met_waddr),
        .i_wdata (met_wdata),
        .i_raddr (met_raddr),
        .o_rdata (met_rdata)
    );

    paf_ram #(
        .WIDTH (paf_pkg::DATA_W),
        .DEPTH (paf_pkg::ARCH_CAP)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // configuration port: zero wait states, write on the access phase
    assign pready = 1'b1;
    always_comb begin
        prdata = (paddr[2] == paf_pkg::REG_CAND_LIMIT) ? {12'b0, r_cand_limit}
                                                       : {27'b0, r_metric_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric_count <= paf_pkg::MC_W'(16);
            r_cand_limit   <= paf_pkg::SEEN_W'(40000);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == paf_pkg::REG_METRIC_COUNT) begin
                r_metric_count <= pwdata[paf_pkg::MC_W-1:0];
            end else begin
                r_cand_limit <= pwdata[paf_pkg::SEEN_W-1:0];
            end
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_load_pos  <= '0;
            r_seen      <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_dst       <= '0;
            r_cb        <= 1'b0;
            r_eb        <= 1'b0;
            r_placed    <= 1'b0;
            r_append    <= 1'b0;
            r_keep      <= '1;
            r_removed   <= '0;
        end else begin
            r_pv <= 1'b0;
            // retire the output register once its transfer completes
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.command == paf_pkg::CMD_LOAD) begin
                            if (r_load_pos < paf_pkg::MPOS_W'(paf_pkg::MAX_MET)) begin
                                r_load_pos <= r_load_pos + 1'b1;
                            end
                            if (i_in_data.last_value) begin
                                r_tag     <= i_in_data.candidate_tag;
                                r_placed  <= 1'b0;
                                r_append  <= 1'b0;
                                r_removed <= '0;
                                r_keep    <= '1;
                                r_j       <= '0;
                                r_i       <= '0;
                                r_cb      <= 1'b0;
                                r_eb      <= 1'b0;
                                r_rval    <= '0;
                                r_rtag    <= '0;
                                r_verdict <= paf_pkg::V_APPENDED;
                                r_state   <= S_CMP;
                            end
                        end else begin
                            r_removed <= '0;
                            if (in_range) begin
                                r_verdict <= paf_pkg::V_READ_OK;
                                r_state   <= S_READ;
                            end else begin
                                r_verdict <= paf_pkg::V_READ_BAD;
                                r_rval    <= '0;
                                r_rtag    <= '0;
                                r_state   <= S_DONE;
                            end
                        end
                    end
                end

                S_CMP: begin
                    if (r_j >= r_valid) begin
                        r_state <= S_END;
                    end else if (r_i < used_n) begin
                        // issue the next metric read, fold in the previous one
                        r_pv <= 1'b1;
                        r_pi <= r_i[paf_pkg::MET_W-1:0];
                        r_i  <= r_i + 1'b1;
                        r_cb <= cb_f;
                        r_eb <= eb_f;
                    end else begin
                        r_i  <= '0;
                        r_cb <= 1'b0;
                        r_eb <= 1'b0;
                        r_j  <= r_j + 1'b1;
                        if (!r_placed) begin
                            if (cb_f && !eb_f) begin
                                r_placed  <= 1'b1;
                                r_verdict <= paf_pkg::V_REPLACED;
                                r_wrow    <= r_j[paf_pkg::ENTRY_W-1:0];
                                r_state   <= S_WRITE;
                            end else if (!cb_f) begin
                                // entry dominates or equals the candidate
                                r_placed  <= 1'b1;
                                r_verdict <= paf_pkg::V_DISCARD;
                                r_state   <= S_FIN;
                            end
                        end else if (cb_f && !eb_f) begin
                            r_keep[r_j[paf_pkg::ENTRY_W-1:0]] <= 1'b0;
                            r_removed <= r_removed + 1'b1;
                        end
                    end
                end

                S_END: begin
                    r_i <= '0;
                    if (!r_placed) begin
                        if (r_valid < paf_pkg::CNT_W'(paf_pkg::ARCH_CAP)) begin
                            r_verdict <= paf_pkg::V_APPENDED;
                            r_wrow    <= r_valid[paf_pkg::ENTRY_W-1:0];
                            r_valid   <= r_valid + 1'b1;
                            r_append  <= 1'b1;
                            r_state   <= S_WRITE;
                        end else begin
                            r_verdict <= paf_pkg::V_DROPPED;
                            r_state   <= S_FIN;
                        end
                    end else if (r_removed != '0) begin
                        r_j     <= '0;
                        r_dst   <= '0;
                        r_state <= S_COPY;
                    end else begin
                        r_state <= S_FIN;
                    end
                end

                S_WRITE: begin
                    if (r_i == paf_pkg::MPOS_W'(paf_pkg::MAX_MET - 1)) begin
                        r_i     <= '0;
                        r_state <= r_append ? S_FIN : S_CMP;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end

                S_COPY: begin
                    if (r_j >= r_valid) begin
                        r_valid <= r_dst;
                        r_state <= S_FIN;
                    end else if (!r_keep[r_j[paf_pkg::ENTRY_W-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else if (r_dst == r_j) begin
                        r_j   <= r_j + 1'b1;
                        r_dst <= r_dst + 1'b1;
                    end else if (r_i < paf_pkg::MPOS_W'(paf_pkg::MAX_MET)) begin
                        r_pv <= 1'b1;
                        r_pi <= r_i[paf_pkg::MET_W-1:0];
                        r_i  <= r_i + 1'b1;
                    end else begin
                        // last word of the row is written this cycle
                        r_i   <= '0;
                        r_j   <= r_j + 1'b1;
                        r_dst <= r_dst + 1'b1;
                    end
                end

                S_FIN: begin
                    r_seen     <= n_seen;
                    r_load_pos <= '0;
                    if (n_seen >= r_cand_limit) begin
                        r_finished <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_READ: begin
                    r_rval  <= met_rdata;
                    r_rtag  <= tag_rdata;
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out.verdict       <= r_verdict;
                        r_out.entry_count   <= r_valid;
                        r_out.removed_count <= r_removed;
                        r_out.finished      <= r_finished;
                        r_out.read_value    <= r_rval;
                        r_out.read_tag      <= r_rtag;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // archive never grows past capacity
    a_valid_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid <= paf_pkg::CNT_W'(paf_pkg::ARCH_CAP))
        else $error("entry count beyond capacity");

    // compaction never writes ahead of its source
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_dst <= r_j))
        else $error("compaction destination ahead of source");

    // a row write always targets a live entry
    a_write_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ({1'b0, r_wrow} < r_valid))
        else $error("row write outside archive");

    // a discarded candidate removes nothing
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_verdict == paf_pkg::V_DISCARD)) |-> (r_removed == '0))
        else $error("discarded candidate removed entries");

    // a result leaves the sequencer only into a free output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !out_free) |=> (r_state == S_DONE))
        else $error("result lost while output busy");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the Pareto archive filter top level.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [paf_pkg::PADDR_W-1:0] ADDR_METRIC_COUNT = 3'd0;
    localparam logic [paf_pkg::PADDR_W-1:0] ADDR_CAND_LIMIT   = 3'd4;
    // Worst closing load: walk, row write and compaction of 64 rows, with margin.
    localparam int SETTLE_CYCLES = 2600;
    localparam int STALL_LIMIT   = 40000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    paf_pkg::t_in                i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    paf_pkg::t_out               o_out_data;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [paf_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    pareto_archive_filter_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the archive and of the configuration.
    logic [31:0] arch_metric [paf_pkg::ARCH_CAP][paf_pkg::MAX_MET];
    logic [31:0] arch_tag [paf_pkg::ARCH_CAP];
    logic [31:0] cand_buf [paf_pkg::MAX_MET];
    int          live_entries;
    int          load_pos;
    int          seen_count;
    logic        done_flag;
    logic [4:0]  cfg_metrics;
    logic [19:0] cfg_limit;

    paf_pkg::t_out pending_results[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    function automatic int metrics_in_use();
        if (cfg_metrics == 0) return 1;
        if (cfg_metrics > paf_pkg::MAX_MET) return paf_pkg::MAX_MET;
        return cfg_metrics;
    endfunction

    // Apply one accepted transfer to the shadow archive; queue any result it causes.
    function automatic void archive_apply(paf_pkg::t_in it);
        paf_pkg::t_out res;
        logic   keep [paf_pkg::ARCH_CAP];
        logic   placed, cand_b, entry_b;
        int     n, dst, removed;
        res = '0;
        n = metrics_in_use();
        if (it.command == paf_pkg::CMD_LOAD) begin
            if (load_pos < paf_pkg::MAX_MET) begin
                cand_buf[load_pos] = it.metric_value;
                load_pos++;
            end
            if (!it.last_value) return;
            placed = 1'b0;
            removed = 0;
            res.verdict = paf_pkg::V_APPENDED;
            foreach (keep[j]) keep[j] = 1'b1;
            for (int j = 0; j < live_entries; j++) begin
                cand_b = 1'b0;
                entry_b = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if ($signed(cand_buf[i]) > $signed(arch_metric[j][i])) cand_b = 1'b1;
                    if ($signed(cand_buf[i]) < $signed(arch_metric[j][i])) entry_b = 1'b1;
                end
                if (!placed) begin
                    if (cand_b && !entry_b) begin
                        arch_metric[j] = cand_buf;
                        arch_tag[j] = it.candidate_tag;
                        placed = 1'b1;
                        res.verdict = paf_pkg::V_REPLACED;
                    end else if (!cand_b) begin
                        placed = 1'b1;
                        res.verdict = paf_pkg::V_DISCARD;
                        break;
                    end
                end else if (cand_b && !entry_b) begin
                    keep[j] = 1'b0;
                    removed++;
                end
            end
            if (!placed) begin
                if (live_entries < paf_pkg::ARCH_CAP) begin
                    arch_metric[live_entries] = cand_buf;
                    arch_tag[live_entries] = it.candidate_tag;
                    live_entries++;
                    res.verdict = paf_pkg::V_APPENDED;
                end else begin
                    res.verdict = paf_pkg::V_DROPPED;
                end
            end
            dst = 0;
            for (int j = 0; j < live_entries; j++) begin
                if (keep[j]) begin
                    arch_metric[dst] = arch_metric[j];
                    arch_tag[dst] = arch_tag[j];
                    dst++;
                end
            end
            live_entries = dst;
            if (seen_count < int'(paf_pkg::SEEN_MAX)) seen_count++;
            if (seen_count >= int'(cfg_limit)) done_flag = 1'b1;
            foreach (cand_buf[i]) cand_buf[i] = '0;
            load_pos = 0;
            res.removed_count = 6'(removed);
        end else begin
            if (it.entry_index < live_entries && it.metric_sel < n) begin
                res.verdict = paf_pkg::V_READ_OK;
                res.read_value = arch_metric[it.entry_index][it.metric_sel];
                res.read_tag = arch_tag[it.entry_index];
            end else begin
                res.verdict = paf_pkg::V_READ_BAD;
            end
        end
        res.entry_count = 7'(live_entries);
        res.finished = done_flag;
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compare each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        paf_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {29'd0, o_out_data.verdict}, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.verdict !== want.verdict)
                    report_mismatch("verdict", 32'(o_out_data.verdict), 32'(want.verdict));
                if (o_out_data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(o_out_data.entry_count),
                                    32'(want.entry_count));
                if (o_out_data.removed_count !== want.removed_count)
                    report_mismatch("removed_count", 32'(o_out_data.removed_count),
                                    32'(want.removed_count));
                if (o_out_data.finished !== want.finished)
                    report_mismatch("finished", 32'(o_out_data.finished), 32'(want.finished));
                if (o_out_data.read_value !== want.read_value)
                    report_mismatch("read_value", o_out_data.read_value, want.read_value);
                if (o_out_data.read_tag !== want.read_tag)
                    report_mismatch("read_tag", o_out_data.read_tag, want.read_tag);
            end
        end
    end

    // Stall the result side at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when no transfer happens on either side for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[pareto_archive_filter_top] ERROR");
            $finish;
        end
    end

    // Send one transfer, idling first at the phase rate; valid stays high into the next item.
    task automatic send_item(input paf_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        archive_apply(it);
    endtask

    // Hold the input idle until every result is back, then let the block settle.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [paf_pkg::PADDR_W-1:0] addr,
                                  input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_METRIC_COUNT) cfg_metrics = value[4:0];
        else cfg_limit = value[19:0];
    endtask

    task automatic configure(input logic [31:0] metrics, input logic [31:0] limit);
        drain_and_settle();
        write_register(ADDR_METRIC_COUNT, metrics);
        write_register(ADDR_CAND_LIMIT, limit);
    endtask

    function automatic paf_pkg::t_in load_item(input logic [31:0] value, input logic last,
                                               input logic [31:0] tag);
        paf_pkg::t_in it;
        it = '0;
        it.command = paf_pkg::CMD_LOAD;
        it.metric_value = value;
        it.last_value = last;
        it.candidate_tag = tag;
        it.entry_index = 6'($urandom);
        it.metric_sel = 4'($urandom);
        return it;
    endfunction

    function automatic paf_pkg::t_in read_item(input int entry, input int metric);
        paf_pkg::t_in it;
        it = paf_pkg::t_in'({$urandom, $urandom, $urandom});
        it.command = paf_pkg::CMD_READ;
        it.entry_index = 6'(entry);
        it.metric_sel = 4'(metric);
        return it;
    endfunction

    // Mostly small values so dominance happens often; extremes and full-range now and then.
    function automatic logic [31:0] pick_metric();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r < 4) return $urandom;
        return 32'($signed($urandom_range(6)) - 3);
    endfunction

    task automatic send_candidate(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] tag);
        send_item(load_item(a, 1'b0, $urandom));
        send_item(load_item(b, 1'b1, tag));
    endtask

    // Extremes, every verdict but dropped, short and long candidates, reads between loads.
    task automatic test_directed();
        configure(32'd2, 32'd3);
        send_item(read_item(0, 0));
        send_candidate(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_candidate(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_candidate(32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_5A5A);
        send_item(load_item(32'd5, 1'b0, 32'h1));
        send_item(read_item(1, 1));
        send_item(read_item(0, 2));
        send_item(read_item(63, 0));
        send_item(load_item(32'd4, 1'b1, 32'h5A5A_A5A5));
        send_item(load_item(32'h7FFF_FFFF, 1'b1, 32'h0000_0042));
        for (int k = 0; k < 18; k++) send_item(load_item(32'h7FFF_FFFF, k == 17, 32'h77));
        send_item(read_item(0, 0));
        send_item(read_item(0, 1));
    endtask

    // Fill the archive with a trade-off front, overflow it, then sweep away part of it.
    task automatic test_full_archive();
        configure(32'd2, 32'hF_FFFF);
        for (int k = 0; k < paf_pkg::ARCH_CAP; k++)
            send_candidate(32'(k - 1000), 32'(-k - 1000), 32'(k));
        send_candidate(32'd500, 32'h8000_0000, 32'hDEAD);
        send_item(read_item(63, 1));
        send_candidate(32'(-990), 32'(-990), 32'hBEEF);
        send_item(read_item(0, 0));
    endtask

    // Random candidates of varied length with reads mixed in.
    task automatic test_random(input int items, input logic [31:0] metrics,
                               input logic [31:0] limit, input int idle_pct,
                               input int stall_pct);
        int sent, len, n;
        configure(metrics, limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        n = metrics_in_use();
        sent = 0;
        len = 0;
        while (sent < items) begin
            if ($urandom_range(4) == 0) begin
                send_item(read_item($urandom_range(3) == 0 ? $urandom_range(63)
                                    : $urandom_range(live_entries),
                                    $urandom_range(15)));
                sent++;
            end else begin
                case ($urandom_range(9))
                    0: len = $urandom_range(1, n);
                    1: len = $urandom_range(n, 18);
                    default: len = n;
                endcase
                for (int k = 0; k < len; k++) begin
                    send_item(load_item(pick_metric(), k == len - 1, $urandom));
                    if (k < len - 1 && $urandom_range(15) == 0) begin
                        send_item(read_item($urandom_range(live_entries), $urandom_range(n)));
                        sent++;
                    end
                end
                sent += len;
            end
            // Hold the sender until the block is empty around the middle of each phase.
            if (sent >= items / 2 && sent < items / 2 + len + 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        cfg_metrics = 5'd16;
        cfg_limit = 20'd40000;
        live_entries = 0;
        load_pos = 0;
        seen_count = 0;
        done_flag = 1'b0;
        foreach (cand_buf[i]) cand_buf[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_archive();
        test_random(160, 32'd3, 32'd1, 0, 0);
        test_random(160, 32'd16, 32'hF_FFFF, 75, 0);
        test_random(120, 32'd0, 32'd100, 0, 75);
        test_random(120, 32'd31, 32'd200, 19, 19);
        test_random(120, 32'd1, 32'd40000, 0, 0);

        drain_and_settle();
        if (error_count == 0) begin
            $display("[pareto_archive_filter_top] OK");
        end else begin
            $display("[pareto_archive_filter_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/paf_pkg.sv
rtl/paf_ram.sv
rtl/paf_cand.sv
rtl/pareto_archive_filter_top.sv
bench/tb_top.sv
